[sv/dtas_pkg.sv]
package dtas_pkg;

  localparam logic [31:0] SECS_MIN  = 32'd60;
  localparam logic [31:0] SECS_HOUR = 32'd3600;
  localparam logic [31:0] SECS_DAY  = 32'd86400;
  localparam logic [31:0] SECS_D28  = 32'd2419200;
  localparam logic [31:0] SECS_D29  = 32'd2505600;
  localparam logic [31:0] SECS_D30  = 32'd2592000;
  localparam logic [31:0] SECS_D31  = 32'd2678400;
  localparam logic [31:0] SECS_NORM = 32'd31536000;
  localparam logic [31:0] SECS_LEAP = 32'd31622400;

  localparam logic [11:0] YEAR_BASE = 12'd2000;
  localparam logic [11:0] YEAR_LAST = 12'd2099;
  localparam logic [3:0]  MONTH_DEC = 4'd12;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_DATE  = 3'd1,
    ST_BAD_TIME  = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_YR_IN,
    S_MO_IN,
    S_DAY_IN,
    S_HR_IN,
    S_MIN_IN,
    S_SEC_IN,
    S_DELTA,
    S_YR_OUT,
    S_MO_OUT,
    S_DAY_OUT,
    S_HR_OUT,
    S_MIN_OUT,
    S_DONE
  } dtas_state_e;

  // shared adder request / response
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic        sub;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] sum;
    logic        carry;   // add: overflow, sub: a >= b
  } alu_rsp_t;

  typedef struct packed {
    logic [11:0] new_year;
    logic [3:0]  new_month;
    logic [4:0]  new_day;
    logic [4:0]  new_hour;
    logic [5:0]  new_minute;
    logic [5:0]  new_sec;
    logic [2:0]  status;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } fin_t;

  function automatic logic [31:0] year_secs(input logic leap);
    return leap ? SECS_LEAP : SECS_NORM;
  endfunction

  function automatic logic [31:0] month_secs(input logic [3:0] m, input logic leap);
    logic [31:0] r;
    r = SECS_D31;
    unique case (m)
      4'd2:                      r = leap ? SECS_D29 : SECS_D28;
      4'd4, 4'd6, 4'd9, 4'd11:   r = SECS_D30;
      default:                   r = SECS_D31;
    endcase
    return r;
  endfunction

endpackage

[sv/dtas_if.sv]
interface dtas_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  sec_field;
  logic [31:0] delta_seconds;

  modport source(output valid, action, year, month, day, hour, minute, sec_field,
                 delta_seconds, input ready);
  modport sink(input valid, action, year, month, day, hour, minute, sec_field,
               delta_seconds, output ready);
endinterface

interface dtas_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] new_year;
  logic [3:0]  new_month;
  logic [4:0]  new_day;
  logic [4:0]  new_hour;
  logic [5:0]  new_minute;
  logic [5:0]  new_sec;
  logic [2:0]  status;

  modport source(output valid, new_year, new_month, new_day, new_hour, new_minute,
                 new_sec, status, input ready);
  modport sink(input valid, new_year, new_month, new_day, new_hour, new_minute,
               new_sec, status, output ready);
endinterface

[sv/date_time_add_subtract_seconds.sv]
// A request with a bad date or time goes straight to the result; any other request walks the
//   years in, applies the delta, then walks years/months/days/hours/minutes out.
// Every step runs through the one shared 33-bit adder, so the run of a request is set by the
//   year and remainder loops, and one request is finished before the next is taken.
// The next request is taken once the sequencer has handed its result to the output register.
// Reset: rst_ni asynchronous, active low; clears sequencer state and the output valid.
module date_time_add_subtract_seconds (
  input  logic      clk_i,
  input  logic      rst_ni,
  dtas_in_if.sink   in_i,
  dtas_out_if.source out_o
);

  dtas_pkg::alu_req_t alu_req;
  dtas_pkg::alu_rsp_t alu_rsp;
  dtas_pkg::fin_t     fin;
  logic               fin_ready;

  logic              out_valid_q, out_valid_d;
  dtas_pkg::result_t res_q, res_d;

  // sequencer: validate, date -> seconds, apply delta, seconds -> date
  dtas_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .alu_req_o   (alu_req),
    .alu_rsp_i   (alu_rsp),
    .fin_o       (fin),
    .fin_ready_i (fin_ready)
  );

  // the one adder/subtractor shared by every step
  dtas_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // output register: frees the sequencer while the result waits
  assign fin_ready = !out_valid_q || out_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (fin.valid && fin_ready) begin
      out_valid_d = 1'b1;
      res_d       = fin.res;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.new_year   = res_q.new_year;
  assign out_o.new_month  = res_q.new_month;
  assign out_o.new_day    = res_q.new_day;
  assign out_o.new_hour   = res_q.new_hour;
  assign out_o.new_minute = res_q.new_minute;
  assign out_o.new_sec    = res_q.new_sec;
  assign out_o.status     = res_q.status;

  // a request keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("request accepted while previous one in flight");

  // status code stays within its defined set
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.status <= dtas_pkg::ST_OVERFLOW))
    else $error("undefined status code");

  // a good result is a well-formed time of day and month
  a_ok_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == dtas_pkg::ST_OK) |->
      (out_o.new_month >= 4'd1 && out_o.new_month <= 4'd12 && out_o.new_day >= 5'd1 &&
       out_o.new_hour <= 5'd23 && out_o.new_minute <= 6'd59 && out_o.new_sec <= 6'd59))
    else $error("result field out of range");

  // output valid only rises after the sequencer finished
  a_rise_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(fin.valid))
    else $error("result without a finished request");

endmodule

[sv/dtas_alu.sv]
module dtas_alu (
  input  dtas_pkg::alu_req_t req_i,
  output dtas_pkg::alu_rsp_t rsp_o
);

  logic [31:0] b_eff;
  logic [32:0] sum;

  assign b_eff = req_i.sub ? ~req_i.b : req_i.b;
  assign sum   = {1'b0, req_i.a} + {1'b0, b_eff} + {32'd0, req_i.sub};

  assign rsp_o.sum   = sum[31:0];
  assign rsp_o.carry = sum[32];

endmodule

[sv/dtas_seq.sv]
module dtas_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  dtas_in_if.sink            in_i,
  output dtas_pkg::alu_req_t alu_req_o,
  input  dtas_pkg::alu_rsp_t alu_rsp_i,
  output dtas_pkg::fin_t     fin_o,
  input  logic               fin_ready_i
);

  dtas_pkg::dtas_state_e state_q, state_d;
  dtas_pkg::status_e     status_q, status_d;

  logic        act_q, act_d;
  logic [11:0] year_q, year_d;
  logic [3:0]  month_q, month_d;
  logic [4:0]  day_q, day_d;
  logic [4:0]  hour_q, hour_d;
  logic [5:0]  min_q, min_d;
  logic [5:0]  sec_q, sec_d;
  logic [31:0] delta_q, delta_d;
  logic [6:0]  yoff_q, yoff_d;
  logic [31:0] acc_q, acc_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [7:0]  yout_q, yout_d;
  logic [3:0]  mo_out_q, mo_out_d;
  logic [4:0]  day_out_q, day_out_d;
  logic [4:0]  hr_out_q, hr_out_d;
  logic [5:0]  min_out_q, min_out_d;

  logic accept, bad_date, bad_time, yr_in_end, mo_in_end, mo_out_last;
  logic fin_valid;
  logic [11:0] yoff_full;

  assign accept    = in_i.valid && in_i.ready;
  assign bad_date  = (in_i.year < dtas_pkg::YEAR_BASE) || (in_i.year > dtas_pkg::YEAR_LAST) ||
                     (in_i.month == 4'd0) || (in_i.month > dtas_pkg::MONTH_DEC) ||
                     (in_i.day == 5'd0);
  assign bad_time  = (in_i.hour > 5'd23) || (in_i.minute > 6'd59) ||
                     (in_i.sec_field > 6'd59);
  assign yoff_full = in_i.year - dtas_pkg::YEAR_BASE;
  assign yr_in_end   = (cnt_q == {1'b0, yoff_q});
  assign mo_in_end   = (cnt_q[3:0] == month_q);
  assign mo_out_last = (cnt_q[3:0] == dtas_pkg::MONTH_DEC);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dtas_pkg::S_IDLE: begin
        if (accept) begin
          state_d = (bad_date || bad_time) ? dtas_pkg::S_DONE : dtas_pkg::S_YR_IN;
        end
      end
      dtas_pkg::S_YR_IN:  if (yr_in_end) state_d = dtas_pkg::S_MO_IN;
      dtas_pkg::S_MO_IN:  if (mo_in_end) state_d = dtas_pkg::S_DAY_IN;
      dtas_pkg::S_DAY_IN: state_d = dtas_pkg::S_HR_IN;
      dtas_pkg::S_HR_IN:  state_d = dtas_pkg::S_MIN_IN;
      dtas_pkg::S_MIN_IN: state_d = dtas_pkg::S_SEC_IN;
      dtas_pkg::S_SEC_IN: state_d = dtas_pkg::S_DELTA;
      dtas_pkg::S_DELTA: begin
        // sub: carry low means borrow; add: carry high means overflow
        if (act_q != alu_rsp_i.carry) state_d = dtas_pkg::S_DONE;
        else                          state_d = dtas_pkg::S_YR_OUT;
      end
      dtas_pkg::S_YR_OUT:  if (!alu_rsp_i.carry) state_d = dtas_pkg::S_MO_OUT;
      dtas_pkg::S_MO_OUT: begin
        if (mo_out_last || !alu_rsp_i.carry) state_d = dtas_pkg::S_DAY_OUT;
      end
      dtas_pkg::S_DAY_OUT: if (!alu_rsp_i.carry) state_d = dtas_pkg::S_HR_OUT;
      dtas_pkg::S_HR_OUT:  if (!alu_rsp_i.carry) state_d = dtas_pkg::S_MIN_OUT;
      dtas_pkg::S_MIN_OUT: if (!alu_rsp_i.carry) state_d = dtas_pkg::S_DONE;
      dtas_pkg::S_DONE:    if (fin_ready_i) state_d = dtas_pkg::S_IDLE;
      default:             state_d = dtas_pkg::S_IDLE;
    endcase
  end

  // outputs: handshake and adder operands
  always_comb begin
    in_i.ready    = 1'b0;
    fin_valid     = 1'b0;
    alu_req_o.a   = acc_q;
    alu_req_o.b   = 32'd0;
    alu_req_o.sub = 1'b0;
    unique case (state_q)
      dtas_pkg::S_IDLE:    in_i.ready = 1'b1;
      dtas_pkg::S_YR_IN:   alu_req_o.b = dtas_pkg::year_secs(cnt_q[1:0] == 2'd0);
      dtas_pkg::S_MO_IN:   alu_req_o.b = dtas_pkg::month_secs(cnt_q[3:0], yoff_q[1:0] == 2'd0);
      dtas_pkg::S_DAY_IN:  alu_req_o.b = 32'(day_q - 5'd1) * dtas_pkg::SECS_DAY;
      dtas_pkg::S_HR_IN:   alu_req_o.b = 32'(hour_q) * dtas_pkg::SECS_HOUR;
      dtas_pkg::S_MIN_IN:  alu_req_o.b = 32'(min_q) * dtas_pkg::SECS_MIN;
      dtas_pkg::S_SEC_IN:  alu_req_o.b = 32'(sec_q);
      dtas_pkg::S_DELTA: begin
        alu_req_o.b   = delta_q;
        alu_req_o.sub = act_q;
      end
      dtas_pkg::S_YR_OUT: begin
        alu_req_o.b   = dtas_pkg::year_secs(cnt_q[1:0] == 2'd0);
        alu_req_o.sub = 1'b1;
      end
      dtas_pkg::S_MO_OUT: begin
        alu_req_o.b   = dtas_pkg::month_secs(cnt_q[3:0], yout_q[1:0] == 2'd0);
        alu_req_o.sub = 1'b1;
      end
      dtas_pkg::S_DAY_OUT: begin
        alu_req_o.b   = dtas_pkg::SECS_DAY;
        alu_req_o.sub = 1'b1;
      end
      dtas_pkg::S_HR_OUT: begin
        alu_req_o.b   = dtas_pkg::SECS_HOUR;
        alu_req_o.sub = 1'b1;
      end
      dtas_pkg::S_MIN_OUT: begin
        alu_req_o.b   = dtas_pkg::SECS_MIN;
        alu_req_o.sub = 1'b1;
      end
      dtas_pkg::S_DONE:    fin_valid = 1'b1;
      default:             fin_valid = 1'b0;
    endcase
  end

  // result: echo the request on any error
  always_comb begin
    fin_o.valid      = fin_valid;
    fin_o.res.status = status_q;
    if (status_q == dtas_pkg::ST_OK) begin
      fin_o.res.new_year   = dtas_pkg::YEAR_BASE + {4'd0, yout_q};
      fin_o.res.new_month  = mo_out_q;
      fin_o.res.new_day    = day_out_q;
      fin_o.res.new_hour   = hr_out_q;
      fin_o.res.new_minute = min_out_q;
      fin_o.res.new_sec    = acc_q[5:0];
    end else begin
      fin_o.res.new_year   = year_q;
      fin_o.res.new_month  = month_q;
      fin_o.res.new_day    = day_q;
      fin_o.res.new_hour   = hour_q;
      fin_o.res.new_minute = min_q;
      fin_o.res.new_sec    = sec_q;
    end
  end

  // datapath
  always_comb begin
    status_d  = status_q;
    act_d     = act_q;
    year_d    = year_q;
    month_d   = month_q;
    day_d     = day_q;
    hour_d    = hour_q;
    min_d     = min_q;
    sec_d     = sec_q;
    delta_d   = delta_q;
    yoff_d    = yoff_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    yout_d    = yout_q;
    mo_out_d  = mo_out_q;
    day_out_d = day_out_q;
    hr_out_d  = hr_out_q;
    min_out_d = min_out_q;
    unique case (state_q)
      dtas_pkg::S_IDLE: begin
        if (accept) begin
          act_d   = in_i.action;
          year_d  = in_i.year;
          month_d = in_i.month;
          day_d   = in_i.day;
          hour_d  = in_i.hour;
          min_d   = in_i.minute;
          sec_d   = in_i.sec_field;
          delta_d = in_i.delta_seconds;
          yoff_d  = yoff_full[6:0];
          acc_d   = 32'd0;
          cnt_d   = 8'd0;
          if (bad_date)      status_d = dtas_pkg::ST_BAD_DATE;
          else if (bad_time) status_d = dtas_pkg::ST_BAD_TIME;
          else               status_d = dtas_pkg::ST_OK;
        end
      end
      dtas_pkg::S_YR_IN: begin
        if (yr_in_end) begin
          cnt_d = 8'd1;
        end else begin
          acc_d = alu_rsp_i.sum;
          cnt_d = cnt_q + 8'd1;
        end
      end
      dtas_pkg::S_MO_IN: begin
        if (!mo_in_end) begin
          acc_d = alu_rsp_i.sum;
          cnt_d = cnt_q + 8'd1;
        end
      end
      dtas_pkg::S_DAY_IN, dtas_pkg::S_HR_IN, dtas_pkg::S_MIN_IN,
      dtas_pkg::S_SEC_IN: acc_d = alu_rsp_i.sum;
      dtas_pkg::S_DELTA: begin
        cnt_d = 8'd0;
        if (act_q && !alu_rsp_i.carry)       status_d = dtas_pkg::ST_UNDERFLOW;
        else if (!act_q && alu_rsp_i.carry)  status_d = dtas_pkg::ST_OVERFLOW;
        else                                 acc_d    = alu_rsp_i.sum;
      end
      dtas_pkg::S_YR_OUT: begin
        if (alu_rsp_i.carry) begin
          acc_d = alu_rsp_i.sum;
          cnt_d = cnt_q + 8'd1;
        end else begin
          yout_d = cnt_q;
          cnt_d  = 8'd1;
        end
      end
      dtas_pkg::S_MO_OUT: begin
        if (mo_out_last || !alu_rsp_i.carry) begin
          mo_out_d = cnt_q[3:0];
          cnt_d    = 8'd0;
        end else begin
          acc_d = alu_rsp_i.sum;
          cnt_d = cnt_q + 8'd1;
        end
      end
      dtas_pkg::S_DAY_OUT: begin
        if (alu_rsp_i.carry) begin
          acc_d = alu_rsp_i.sum;
          cnt_d = cnt_q + 8'd1;
        end else begin
          day_out_d = cnt_q[4:0] + 5'd1;
          cnt_d     = 8'd0;
        end
      end
      dtas_pkg::S_HR_OUT: begin
        if (alu_rsp_i.carry) begin
          acc_d = alu_rsp_i.sum;
          cnt_d = cnt_q + 8'd1;
        end else begin
          hr_out_d = cnt_q[4:0];
          cnt_d    = 8'd0;
        end
      end
      dtas_pkg::S_MIN_OUT: begin
        if (alu_rsp_i.carry) begin
          acc_d = alu_rsp_i.sum;
          cnt_d = cnt_q + 8'd1;
        end else begin
          min_out_d = cnt_q[5:0];
        end
      end
      dtas_pkg::S_DONE: acc_d = acc_q;
      default:          acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= dtas_pkg::S_IDLE;
      status_q <= dtas_pkg::ST_OK;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q     <= act_d;
    year_q    <= year_d;
    month_q   <= month_d;
    day_q     <= day_d;
    hour_q    <= hour_d;
    min_q     <= min_d;
    sec_q     <= sec_d;
    delta_q   <= delta_d;
    yoff_q    <= yoff_d;
    acc_q     <= acc_d;
    cnt_q     <= cnt_d;
    yout_q    <= yout_d;
    mo_out_q  <= mo_out_d;
    day_out_q <= day_out_d;
    hr_out_q  <= hr_out_d;
    min_out_q <= min_out_d;
  end

endmodule

[bench/dtas_checker.sv]
`timescale 1ns / 1ps

package dtas_tb_pkg;

  // action bit of a request
  localparam logic ACT_ADD = 1'b0;
  localparam logic ACT_SUB = 1'b1;

endpackage

module dtas_checker
  import dtas_pkg::*;
  import dtas_tb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  dtas_in_if   req_i,
  dtas_out_if  rsp_i,
  output int   mismatch_count_o,
  output int   pending_o
);

  localparam longint unsigned DAY_S        = 64'd86400;
  localparam longint unsigned LEAP_YEAR_S  = 64'd366 * DAY_S;
  localparam longint unsigned PLAIN_YEAR_S = 64'd365 * DAY_S;
  localparam longint unsigned U32_MAX      = 64'hFFFF_FFFF;

  result_t expected_dates_q[$];
  int      mismatches = 0;

  function automatic longint unsigned month_len_s(input int unsigned m, input bit leap);
    case (m)
      2:             return leap ? 64'd29 * DAY_S : 64'd28 * DAY_S;
      4, 6, 9, 11:   return 64'd30 * DAY_S;
      default:       return 64'd31 * DAY_S;
    endcase
  endfunction

  // leap rule is purely offset mod 4 from 2000
  function automatic longint unsigned year_len_s(input int unsigned off);
    return (off % 4 == 0) ? LEAP_YEAR_S : PLAIN_YEAR_S;
  endfunction

  function automatic result_t shift_date(input logic act, input logic [11:0] yr,
                                         input logic [3:0] mo, input logic [4:0] dy,
                                         input logic [4:0] hr, input logic [5:0] mi,
                                         input logic [5:0] sc, input logic [31:0] delta);
    result_t           r;
    status_e           st;
    longint unsigned   secs;
    int unsigned       off;
    int unsigned       m;
    int unsigned       years_in;
    st   = ST_OK;
    secs = 0;
    if (yr < YEAR_BASE || yr > YEAR_LAST || mo < 4'd1 || mo > MONTH_DEC || dy < 5'd1) begin
      st = ST_BAD_DATE;
    end else if (hr > 5'd23 || mi > 6'd59 || sc > 6'd59) begin
      st = ST_BAD_TIME;
    end
    if (st == ST_OK) begin
      years_in = 32'(yr - YEAR_BASE);
      for (off = 0; off < years_in; off++) secs += year_len_s(off);
      for (m = 1; m < 32'(mo); m++) secs += month_len_s(m, yr[1:0] == 2'b00);
      secs += (64'(dy) - 64'd1) * DAY_S + 64'(hr) * 64'd3600 + 64'(mi) * 64'd60 + 64'(sc);
      if (act == ACT_SUB) begin
        if (64'(delta) > secs) st = ST_UNDERFLOW;
        else secs -= 64'(delta);
      end else begin
        secs += 64'(delta);
        if (secs > U32_MAX) st = ST_OVERFLOW;
      end
    end
    if (st == ST_OK) begin
      off = 0;
      while (year_len_s(off) <= secs) begin
        secs -= year_len_s(off);
        off++;
      end
      m = 1;
      while (m < 32'(MONTH_DEC) && month_len_s(m, off % 4 == 0) <= secs) begin
        secs -= month_len_s(m, off % 4 == 0);
        m++;
      end
      r.new_year   = 12'(32'(YEAR_BASE) + off);
      r.new_month  = 4'(m);
      r.new_day    = 5'(secs / DAY_S + 64'd1);
      secs         = secs % DAY_S;
      r.new_hour   = 5'(secs / 64'd3600);
      r.new_minute = 6'((secs % 64'd3600) / 64'd60);
      r.new_sec    = 6'(secs % 64'd60);
    end else begin
      // errors echo the request date/time
      r.new_year   = yr;
      r.new_month  = mo;
      r.new_day    = dy;
      r.new_hour   = hr;
      r.new_minute = mi;
      r.new_sec    = sc;
    end
    r.status = st;
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (rsp_i.valid && rsp_i.ready) begin
        got = {rsp_i.new_year, rsp_i.new_month, rsp_i.new_day, rsp_i.new_hour,
               rsp_i.new_minute, rsp_i.new_sec, rsp_i.status};
        if (expected_dates_q.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          want = expected_dates_q.pop_front();
          check_field("new_year", 32'(want.new_year), 32'(got.new_year));
          check_field("new_month", 32'(want.new_month), 32'(got.new_month));
          check_field("new_day", 32'(want.new_day), 32'(got.new_day));
          check_field("new_hour", 32'(want.new_hour), 32'(got.new_hour));
          check_field("new_minute", 32'(want.new_minute), 32'(got.new_minute));
          check_field("new_sec", 32'(want.new_sec), 32'(got.new_sec));
          check_field("status", 32'(want.status), 32'(got.status));
        end
      end
      if (req_i.valid && req_i.ready) begin
        expected_dates_q.push_back(shift_date(req_i.action, req_i.year, req_i.month,
                                              req_i.day, req_i.hour, req_i.minute,
                                              req_i.sec_field, req_i.delta_seconds));
      end
    end
    mismatch_count_o <= mismatches;
    pending_o        <= expected_dates_q.size();
  end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the date/time add-subtract block. Checking lives in
// dtas_checker, which watches both channels and reports mismatches and the
// number of requests still waiting for a result.
module testbench;
  import dtas_pkg::*;
  import dtas_tb_pkg::*;

  localparam int          RANDOM_REQUESTS = 450;
  localparam int          HOLD_CYCLES     = 2000;   // one long output stall
  localparam int          DRAIN_CYCLES    = 400;    // a bit over worst-case latency
  // ~475 requests plus stalls; keep 5x margin over the expected run
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;

  logic clk_i;
  logic rst_ni;
  logic no_idle;          // window where neither side inserts bubbles
  int   mismatch_count;
  int   pending;

  dtas_in_if  req_if ();
  dtas_out_if rsp_if ();

  date_time_add_subtract_seconds u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  dtas_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_i            (req_if),
    .rsp_i            (rsp_if),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Called at a falling edge; returns at the falling edge after the request
  // was taken. valid stays high across back-to-back requests.
  task automatic send_request(input logic act, input logic [11:0] yr, input logic [3:0] mo,
                              input logic [4:0] dy, input logic [4:0] hr,
                              input logic [5:0] mi, input logic [5:0] sc,
                              input logic [31:0] delta);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(99) < 20) gap = $urandom_range(6, 1);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.action        <= act;
    req_if.year          <= yr;
    req_if.month         <= mo;
    req_if.day           <= dy;
    req_if.hour          <= hr;
    req_if.minute        <= mi;
    req_if.sec_field     <= sc;
    req_if.delta_seconds <= delta;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  // Request side: directed corners, then random requests, then drain.
  initial begin
    logic        act;
    logic [11:0] yr;
    logic [3:0]  mo;
    logic [4:0]  dy;
    logic [4:0]  hr;
    logic [5:0]  mi;
    logic [5:0]  sc;
    logic [31:0] delta;
    int          kind;
    rst_ni               = 1'b0;
    no_idle              = 1'b0;
    req_if.valid         = 1'b0;
    req_if.action        = ACT_ADD;
    req_if.year          = '0;
    req_if.month         = '0;
    req_if.day           = '0;
    req_if.hour          = '0;
    req_if.minute        = '0;
    req_if.sec_field     = '0;
    req_if.delta_seconds = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // epoch itself, zero deltas, landing exactly on the epoch
    send_request(ACT_ADD, 12'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 32'd0);
    send_request(ACT_SUB, 12'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 32'd0);
    send_request(ACT_SUB, 12'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd1, 32'd1);
    // one second below the epoch
    send_request(ACT_SUB, 12'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 32'd1);
    // largest reachable total, then overflow and underflow from the far end
    send_request(ACT_ADD, 12'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 32'hFFFF_FFFF);
    send_request(ACT_ADD, 12'd2099, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 32'hFFFF_FFFF);
    send_request(ACT_SUB, 12'd2099, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 32'hFFFF_FFFF);
    send_request(ACT_SUB, 12'd2099, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 32'd3_000_000_000);
    // bad dates; the all-ones one also has a bad time, date check must win
    send_request(ACT_ADD, 12'd1999, 4'd12, 5'd31, 5'd0, 6'd0, 6'd0, 32'd5);
    send_request(ACT_ADD, 12'd2100, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 32'd5);
    send_request(ACT_SUB, 12'd4095, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 32'hFFFF_FFFF);
    send_request(ACT_ADD, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'd0);
    send_request(ACT_ADD, 12'd2050, 4'd13, 5'd1, 5'd0, 6'd0, 6'd0, 32'd0);
    send_request(ACT_ADD, 12'd2050, 4'd6, 5'd0, 5'd0, 6'd0, 6'd0, 32'd0);
    // bad times on a good date
    send_request(ACT_ADD, 12'd2050, 4'd6, 5'd15, 5'd24, 6'd0, 6'd0, 32'd0);
    send_request(ACT_ADD, 12'd2050, 4'd6, 5'd15, 5'd0, 6'd60, 6'd0, 32'd0);
    send_request(ACT_ADD, 12'd2050, 4'd6, 5'd15, 5'd0, 6'd0, 6'd60, 32'd0);
    send_request(ACT_SUB, 12'd2050, 4'd6, 5'd15, 5'd31, 6'd63, 6'd63, 32'd0);
    // day past month end rolls into the next month
    send_request(ACT_ADD, 12'd2001, 4'd2, 5'd31, 5'd12, 6'd0, 6'd0, 32'd0);
    send_request(ACT_ADD, 12'd2001, 4'd4, 5'd31, 5'd0, 6'd0, 6'd0, 32'd0);
    // leap day and year boundaries
    send_request(ACT_ADD, 12'd2004, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0, 32'd86400);
    send_request(ACT_ADD, 12'd2003, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 32'd1);
    send_request(ACT_SUB, 12'd2005, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0, 32'd1);
    send_request(ACT_SUB, 12'd2004, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0, 32'd1);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      no_idle <= (i >= 200 && i < 300);
      kind  = $urandom_range(99);
      act   = 1'($urandom_range(1));
      delta = $urandom;
      if (kind < 8) begin
        // raw noise over every field bit
        yr = 12'($urandom);
        mo = 4'($urandom);
        dy = 5'($urandom);
        hr = 5'($urandom);
        mi = 6'($urandom);
        sc = 6'($urandom);
      end else begin
        yr = YEAR_BASE + 12'($urandom_range(99));
        mo = 4'($urandom_range(12, 1));
        dy = 5'($urandom_range(31, 1));
        if (kind < 15) begin
          // good date, time fields unconstrained
          hr = 5'($urandom);
          mi = 6'($urandom);
          sc = 6'($urandom);
        end else begin
          hr = 5'($urandom_range(23));
          mi = 6'($urandom_range(59));
          sc = 6'($urandom_range(59));
          case ($urandom_range(3))
            0:       delta = $urandom_range(100_000);
            1:       delta = $urandom_range(32'h0800_0000);
            2:       delta = $urandom_range(32'h4000_0000);
            default: delta = $urandom;
          endcase
        end
      end
      send_request(act, yr, mo, dy, hr, mi, sc, delta);
    end
    req_if.valid <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Result side: random back-pressure, plus one long stall so the block
  // fills and pushes back on the request side.
  initial begin
    int delivered;
    bit held;
    delivered    = 0;
    held         = 1'b0;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (delivered >= 30 && !held) begin
        held = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        rsp_if.ready <= no_idle || $urandom_range(99) >= 20;
      end
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) delivered++;
    end
  end

  // Watchdog.
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[date_time_add_subtract_seconds.f]
sv/dtas_pkg.sv
sv/dtas_if.sv
sv/dtas_alu.sv
sv/dtas_seq.sv
sv/date_time_add_subtract_seconds.sv
bench/dtas_checker.sv
bench/testbench.sv
